### rtl/bda_pkg.sv
// Shared constants for the button debounce and autorepeat block.
// Tone codes, register indexes and reset values; no dependencies.
`default_nettype none
package bda_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;

   localparam int DIVIDER_W = 8;
   localparam int HOLD_W    = 15;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 15;
   localparam int TONE_W    = 3;

   localparam logic [DIVIDER_W-1:0] DIVIDER_RESET = 8'd78;
   localparam logic [HOLD_W-1:0]    HOLD_RESET    = 15'd22;
   localparam logic [HOLD_W-1:0]    REPEAT_RESET  = 15'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_DIVIDER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AUTOREPEAT_ON  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_SAMPLES   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_SAMPLES = 2'd3;

   localparam logic [TONE_W-1:0] TONE_NONE       = 3'd0;
   localparam logic [TONE_W-1:0] TONE_NAV_PRESS  = 3'd1;
   localparam logic [TONE_W-1:0] TONE_NAV_REPEAT = 3'd2;
   localparam logic [TONE_W-1:0] TONE_POWER      = 3'd3;
   localparam logic [TONE_W-1:0] TONE_SELECT     = 3'd4;

endpackage
`default_nettype wire

### rtl/button_debounce_autorepeat.sv
// Button sampler with prescaler, hold counters, autorepeat and beep tone.
// Depends on bda_pkg for register indexes, reset values and tone codes.
// Path: an accepted tick transaction goes through the input register, then the
// result register. Throughput: one tick per cycle; a stalled result holds a tick
// in each register and drops req_ready, which follows rsp_ready.
// Reset: synchronous, active high; registers take their reset values, the
// prescaler loads 78 and hold counters clear. No clearing pass.
`default_nettype none
module button_debounce_autorepeat #(
   parameter int COUNT_BITS = bda_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic                            req_up_pin_n,
   input  wire logic                            req_down_pin_n,
   input  wire logic                            req_power_pin_n,
   input  wire logic                            req_select_pin_n,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic                            rsp_sampled,
   output      logic                            rsp_up_event,
   output      logic                            rsp_down_event,
   output      logic                            rsp_select_event,
   output      logic                            rsp_power_event,
   output      logic                            rsp_up_held,
   output      logic                            rsp_down_held,
   output      logic                            rsp_select_held,
   output      logic [bda_pkg::TONE_W-1:0]      rsp_beep_tone,
   input  wire logic                            csr_we,
   input  wire logic [bda_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bda_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bda_pkg::*;

   localparam int SUM_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   logic [DIVIDER_W-1:0]  divider_ff;
   logic                  autorepeat_ff;
   logic [HOLD_W-1:0]     hold_ff;
   logic [HOLD_W-1:0]     repeat_ff;

   logic                  in_valid_ff;
   logic [3:0]            in_pins_ff;
   logic                  advance;

   logic [DIVIDER_W-1:0]  prescale_ff, prescale_in, prescale_dec;
   logic [COUNT_BITS-1:0] up_cnt_ff, up_cnt_in;
   logic [COUNT_BITS-1:0] down_cnt_ff, down_cnt_in;
   logic [COUNT_BITS-1:0] sel_cnt_ff, sel_cnt_in;
   logic                  power_was_ff, power_was_in;

   logic                  sample;
   logic                  up_p, down_p, power_p, sel_p;
   logic                  up_press, up_rep, down_press, down_rep;
   logic                  sel_press, sel_rep, pow_ev;
   logic [TONE_W-1:0]     tone;
   logic [SUM_W:0]        limit;

   logic                  rsp_valid_ff;
   logic                  sampled_ff, up_ev_ff, down_ev_ff, sel_ev_ff, pow_ev_ff;
   logic                  up_held_ff, down_held_ff, sel_held_ff;
   logic [TONE_W-1:0]     tone_ff;

   function automatic logic is_rep(input logic [COUNT_BITS-1:0] cnt, input logic pressed);
      is_rep = pressed && autorepeat_ff && (SUM_W'(cnt) == SUM_W'(hold_ff));
   endfunction

   function automatic logic [COUNT_BITS-1:0] hold_next(input logic [COUNT_BITS-1:0] cnt,
                                                       input logic pressed);
      logic [COUNT_BITS-1:0] inc;
      logic [SUM_W-1:0]      hold_ext;
      inc      = cnt + 1'b1;
      hold_ext = SUM_W'(hold_ff);
      if (!pressed) begin
         hold_next = '0;
      end else if ((SUM_W+1)'(inc) > limit) begin
         hold_next = hold_ext[COUNT_BITS-1:0];
      end else begin
         hold_next = inc;
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff    <= DIVIDER_RESET;
         autorepeat_ff <= 1'b0;
         hold_ff       <= HOLD_RESET;
         repeat_ff     <= REPEAT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SAMPLE_DIVIDER: divider_ff    <= csr_wdata[DIVIDER_W-1:0];
            CSR_AUTOREPEAT_ON:  autorepeat_ff <= csr_wdata[0];
            CSR_HOLD_SAMPLES:   hold_ff       <= csr_wdata[HOLD_W-1:0];
            CSR_REPEAT_SAMPLES: repeat_ff     <= csr_wdata[HOLD_W-1:0];
            default:            divider_ff    <= divider_ff;
         endcase
      end
   end

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_pins_ff <= {req_select_pin_n, req_power_pin_n, req_down_pin_n, req_up_pin_n};
      end
   end

   assign up_p    = !in_pins_ff[0];
   assign down_p  = !in_pins_ff[1];
   assign power_p = !in_pins_ff[2];
   assign sel_p   = !in_pins_ff[3];

   assign prescale_dec = prescale_ff - 1'b1;
   assign sample       = (prescale_dec == '0);
   assign limit        = (SUM_W+1)'(hold_ff) + (SUM_W+1)'(repeat_ff);

   assign down_press = down_p && (down_cnt_ff == '0);
   assign down_rep   = is_rep(down_cnt_ff, down_p);
   assign up_press   = up_p && (up_cnt_ff == '0);
   assign up_rep     = is_rep(up_cnt_ff, up_p);
   assign sel_press  = sel_p && (sel_cnt_ff == '0);
   assign sel_rep    = is_rep(sel_cnt_ff, sel_p);
   assign pow_ev     = power_p && !power_was_ff;

   always_comb begin
      tone = TONE_NONE;
      if (down_press) begin
         tone = TONE_NAV_PRESS;
      end
      if (down_rep) begin
         tone = TONE_NAV_REPEAT;
      end
      if (up_press) begin
         tone = TONE_NAV_PRESS;
      end
      if (up_rep) begin
         tone = TONE_NAV_REPEAT;
      end
      if (pow_ev) begin
         tone = TONE_POWER;
      end
      if (sel_press) begin
         tone = TONE_SELECT;
      end
   end

   always_comb begin
      prescale_in  = prescale_ff;
      up_cnt_in    = up_cnt_ff;
      down_cnt_in  = down_cnt_ff;
      sel_cnt_in   = sel_cnt_ff;
      power_was_in = power_was_ff;
      if (advance) begin
         prescale_in = prescale_dec;
         if (sample) begin
            prescale_in  = divider_ff;
            up_cnt_in    = hold_next(up_cnt_ff, up_p);
            down_cnt_in  = hold_next(down_cnt_ff, down_p);
            sel_cnt_in   = hold_next(sel_cnt_ff, sel_p);
            power_was_in = power_p;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff  <= DIVIDER_RESET;
         up_cnt_ff    <= '0;
         down_cnt_ff  <= '0;
         sel_cnt_ff   <= '0;
         power_was_ff <= 1'b0;
      end else begin
         prescale_ff  <= prescale_in;
         up_cnt_ff    <= up_cnt_in;
         down_cnt_ff  <= down_cnt_in;
         sel_cnt_ff   <= sel_cnt_in;
         power_was_ff <= power_was_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sampled_ff   <= sample;
         up_ev_ff     <= sample && (up_press || up_rep);
         down_ev_ff   <= sample && (down_press || down_rep);
         sel_ev_ff    <= sample && (sel_press || sel_rep);
         pow_ev_ff    <= sample && pow_ev;
         up_held_ff   <= sample && up_p;
         down_held_ff <= sample && down_p;
         sel_held_ff  <= sample && sel_p;
         tone_ff      <= sample ? tone : TONE_NONE;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sampled      = sampled_ff;
   assign rsp_up_event     = up_ev_ff;
   assign rsp_down_event   = down_ev_ff;
   assign rsp_select_event = sel_ev_ff;
   assign rsp_power_event  = pow_ev_ff;
   assign rsp_up_held      = up_held_ff;
   assign rsp_down_held    = down_held_ff;
   assign rsp_select_held  = sel_held_ff;
   assign rsp_beep_tone    = tone_ff;

   a_quiet_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sampled |-> !rsp_up_event && !rsp_down_event &&
      !rsp_select_event && !rsp_power_event && rsp_beep_tone == TONE_NONE)
      else $error("non-sample tick carries an event");

   a_event_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_up_event || rsp_down_event || rsp_select_event) |->
      (!rsp_up_event || rsp_up_held) && (!rsp_down_event || rsp_down_held) &&
      (!rsp_select_event || rsp_select_held))
      else $error("event without held button");

   a_power_edge: assert property (@(posedge clock) disable iff (reset)
      advance && sample && pow_ev |=> power_was_ff && rsp_power_event)
      else $error("power edge not recorded");

   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      advance && sample && !up_p |=> up_cnt_ff == '0)
      else $error("up counter not cleared on release");

endmodule
`default_nettype wire

### bench/tb.sv
// Testbench for button_debounce_autorepeat: a directed table, then random phases of
// button traffic, with every result transaction checked against a table entry or an in-bench prediction.
// Depends on bda_pkg and the RTL top level only.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bda_pkg::*;

   localparam int COUNT_W      = COUNT_BITS_DEFAULT;
   localparam int RANDOM_ITEMS = 1044;
   localparam int QUIET_ITEMS  = 150;
   localparam int LONG_STALL   = 80;
   localparam int CYCLE_LIMIT  = 400000;

   // pin vectors: {up, down, power, select}, active low
   localparam logic [3:0] PINS_IDLE     = 4'b1111;
   localparam logic [3:0] PINS_UP       = 4'b0111;
   localparam logic [3:0] PINS_DOWN     = 4'b1011;
   localparam logic [3:0] PINS_POWER    = 4'b1101;
   localparam logic [3:0] PINS_SELECT   = 4'b1110;
   localparam logic [3:0] PINS_ALL      = 4'b0000;
   localparam logic [3:0] PINS_UP_DOWN  = 4'b0011;
   localparam logic [3:0] PINS_UP_POWER = 4'b0101;

   typedef struct packed {
      logic              sampled;
      logic              up_event;
      logic              down_event;
      logic              select_event;
      logic              power_event;
      logic              up_held;
      logic              down_held;
      logic              select_held;
      logic [TONE_W-1:0] beep_tone;
   } tick_result_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               fired;
      logic [TONE_W-1:0]  tone;
   } hold_next_type;

   typedef enum logic {ROW_TICK, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [3:0]            pins;
      logic [7:0]            reps;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      logic                  typed;
      tick_result_type       want;
   } stim_row_type;

   localparam tick_result_type QUIET_TICK  = '0;
   localparam tick_result_type IDLE_SAMPLE = '{sampled: 1'b1, default: '0};

   localparam stim_row_type DIRECTED [21] = '{
      '{ROW_TICK, PINS_IDLE,     8'd1,  CSR_SAMPLE_DIVIDER, 15'd0, 1'b1, QUIET_TICK},
      '{ROW_CSR,  PINS_IDLE,     8'd0,  CSR_SAMPLE_DIVIDER, 15'd1, 1'b0, QUIET_TICK},
      '{ROW_TICK, PINS_IDLE,     8'd76, CSR_SAMPLE_DIVIDER, 15'd0, 1'b1, QUIET_TICK},
      '{ROW_TICK, PINS_IDLE,     8'd1,  CSR_SAMPLE_DIVIDER, 15'd0, 1'b1, IDLE_SAMPLE},
      '{ROW_TICK, PINS_UP,       8'd2,  CSR_SAMPLE_DIVIDER, 15'd0, 1'b0, QUIET_TICK},
      '{ROW_TICK, PINS_DOWN,     8'd1,  CSR_SAMPLE_DIVIDER, 15'd0, 1'b0, QUIET_TICK},
      '{ROW_TICK, PINS_POWER,    8'd2,  CSR_SAMPLE_DIVIDER, 15'd0, 1'b0, QUIET_TICK},
      '{ROW_TICK, PINS_SELECT,   8'd2,  CSR_SAMPLE_DIVIDER, 15'd0, 1'b0, QUIET_TICK},
      '{ROW_TICK, PINS_ALL,      8'd1,  CSR_SAMPLE_DIVIDER, 15'd0, 1'b0, QUIET_TICK},
      '{ROW_TICK, PINS_IDLE,     8'd1,  CSR_SAMPLE_DIVIDER, 15'd0, 1'b1, IDLE_SAMPLE},
      '{ROW_CSR,  PINS_IDLE,     8'd0,  CSR_AUTOREPEAT_ON,  15'd1, 1'b0, QUIET_TICK},
      '{ROW_CSR,  PINS_IDLE,     8'd0,  CSR_HOLD_SAMPLES,   15'd0, 1'b0, QUIET_TICK},
      '{ROW_CSR,  PINS_IDLE,     8'd0,  CSR_REPEAT_SAMPLES, 15'd0, 1'b0, QUIET_TICK},
      '{ROW_TICK, PINS_ALL,      8'd3,  CSR_SAMPLE_DIVIDER, 15'd0, 1'b0, QUIET_TICK},
      '{ROW_TICK, PINS_IDLE,     8'd1,  CSR_SAMPLE_DIVIDER, 15'd0, 1'b1, IDLE_SAMPLE},
      '{ROW_CSR,  PINS_IDLE,     8'd0,  CSR_HOLD_SAMPLES,   15'd2, 1'b0, QUIET_TICK},
      '{ROW_CSR,  PINS_IDLE,     8'd0,  CSR_REPEAT_SAMPLES, 15'd1, 1'b0, QUIET_TICK},
      '{ROW_TICK, PINS_UP_DOWN,  8'd7,  CSR_SAMPLE_DIVIDER, 15'd0, 1'b0, QUIET_TICK},
      '{ROW_TICK, PINS_SELECT,   8'd5,  CSR_SAMPLE_DIVIDER, 15'd0, 1'b0, QUIET_TICK},
      '{ROW_TICK, PINS_UP_POWER, 8'd2,  CSR_SAMPLE_DIVIDER, 15'd0, 1'b0, QUIET_TICK},
      '{ROW_TICK, PINS_IDLE,     8'd1,  CSR_SAMPLE_DIVIDER, 15'd0, 1'b1, IDLE_SAMPLE}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_up_pin_n = 1'b1;
   logic                  req_down_pin_n = 1'b1;
   logic                  req_power_pin_n = 1'b1;
   logic                  req_select_pin_n = 1'b1;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_sampled;
   logic                  rsp_up_event;
   logic                  rsp_down_event;
   logic                  rsp_select_event;
   logic                  rsp_power_event;
   logic                  rsp_up_held;
   logic                  rsp_down_held;
   logic                  rsp_select_held;
   logic [TONE_W-1:0]     rsp_beep_tone;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predicted block state and register copies
   logic [DIVIDER_W-1:0] divider_cfg = DIVIDER_RESET;
   logic                 rpt_on = 1'b0;
   logic [HOLD_W-1:0]    hold_cfg = HOLD_RESET;
   logic [HOLD_W-1:0]    repeat_cfg = REPEAT_RESET;
   logic [DIVIDER_W-1:0] prescale = DIVIDER_RESET;
   logic [COUNT_W-1:0]   up_count = '0;
   logic [COUNT_W-1:0]   down_count = '0;
   logic [COUNT_W-1:0]   select_count = '0;
   logic                 power_was = 1'b0;

   tick_result_type awaited_results [$];
   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              send_idle_pct = 15;
   int              rsp_idle_pct = 15;
   bit              quiet = 1'b0;
   bit              long_stall_req = 1'b0;

   button_debounce_autorepeat DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_up_pin_n     (req_up_pin_n),
      .req_down_pin_n   (req_down_pin_n),
      .req_power_pin_n  (req_power_pin_n),
      .req_select_pin_n (req_select_pin_n),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sampled      (rsp_sampled),
      .rsp_up_event     (rsp_up_event),
      .rsp_down_event   (rsp_down_event),
      .rsp_select_event (rsp_select_event),
      .rsp_power_event  (rsp_power_event),
      .rsp_up_held      (rsp_up_held),
      .rsp_down_held    (rsp_down_held),
      .rsp_select_held  (rsp_select_held),
      .rsp_beep_tone    (rsp_beep_tone),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic hold_next_type advance_hold(logic [COUNT_W-1:0] count, logic pressed,
                                                  logic [TONE_W-1:0] press_tone,
                                                  logic [TONE_W-1:0] repeat_tone);
      hold_next_type nxt;
      nxt = '{count: '0, fired: 1'b0, tone: TONE_NONE};
      if (pressed) begin
         if (count == '0) begin
            nxt.fired = 1'b1;
            nxt.tone = press_tone;
         end
         if (rpt_on && count == COUNT_W'(hold_cfg)) begin
            nxt.fired = 1'b1;
            if (repeat_tone != TONE_NONE) nxt.tone = repeat_tone;
         end
         nxt.count = count + 1'b1;
         if (int'(nxt.count) > int'(hold_cfg) + int'(repeat_cfg)) nxt.count = COUNT_W'(hold_cfg);
      end
      return nxt;
   endfunction

   function automatic tick_result_type scan_buttons(logic [3:0] pins);
      tick_result_type res;
      hold_next_type   h;
      res = '0;
      prescale = prescale - 1'b1;
      if (prescale != '0) return res;
      prescale = divider_cfg;
      res.sampled = 1'b1;
      res.up_held = ~pins[3];
      res.down_held = ~pins[2];
      res.select_held = ~pins[0];
      h = advance_hold(down_count, ~pins[2], TONE_NAV_PRESS, TONE_NAV_REPEAT);
      down_count = h.count;
      res.down_event = h.fired;
      if (h.tone != TONE_NONE) res.beep_tone = h.tone;
      h = advance_hold(up_count, ~pins[3], TONE_NAV_PRESS, TONE_NAV_REPEAT);
      up_count = h.count;
      res.up_event = h.fired;
      if (h.tone != TONE_NONE) res.beep_tone = h.tone;
      if (!pins[1] && !power_was) begin
         res.power_event = 1'b1;
         res.beep_tone = TONE_POWER;
      end
      power_was = ~pins[1];
      h = advance_hold(select_count, ~pins[0], TONE_SELECT, TONE_NONE);
      select_count = h.count;
      res.select_event = h.fired;
      if (h.tone != TONE_NONE) res.beep_tone = h.tone;
      return res;
   endfunction

   task automatic send_tick(input logic [3:0] pins, input logic typed,
                            input tick_result_type want);
      tick_result_type predicted;
      csr_we <= 1'b0;
      if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_up_pin_n, req_down_pin_n, req_power_pin_n, req_select_pin_n} <= pins;
      do @(posedge clock); while (!req_ready);
      predicted = scan_buttons(pins);
      awaited_results.push_back(typed ? want : predicted);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      csr_we <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      settle();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_SAMPLE_DIVIDER: divider_cfg = data[DIVIDER_W-1:0];
         CSR_AUTOREPEAT_ON:  rpt_on = data[0];
         CSR_HOLD_SAMPLES:   hold_cfg = data[HOLD_W-1:0];
         CSR_REPEAT_SAMPLES: repeat_cfg = data[HOLD_W-1:0];
      endcase
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   initial begin : rsp_side
      int              hold_left;
      tick_result_type got;
      tick_result_type want;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got = '{rsp_sampled, rsp_up_event, rsp_down_event, rsp_select_event,
                    rsp_power_event, rsp_up_held, rsp_down_held, rsp_select_held,
                    rsp_beep_tone};
            if (awaited_results.size() == 0) begin
               $error("result transaction with none outstanding");
               mismatch_count++;
            end else begin
               want = awaited_results.pop_front();
               check_field("sampled", want.sampled, got.sampled);
               check_field("up_event", want.up_event, got.up_event);
               check_field("down_event", want.down_event, got.down_event);
               check_field("select_event", want.select_event, got.select_event);
               check_field("power_event", want.power_event, got.power_event);
               check_field("up_held", want.up_held, got.up_held);
               check_field("down_held", want.down_held, got.down_held);
               check_field("select_held", want.select_held, got.select_held);
               check_field("beep_tone", want.beep_tone, got.beep_tone);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (long_stall_req) begin
            long_stall_req = 1'b0;
            hold_left = LONG_STALL - 1;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 99) < rsp_idle_pct) begin
            hold_left = $urandom_range(0, 13);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : req_side
      int                    random_sent;
      int                    phase;
      int                    phase_len;
      int                    div_ticks;
      int                    pick;
      int                    run_left [4];
      logic [3:0]            levels;
      logic [DIVIDER_W-1:0]  div;
      logic                  auto_on;
      logic [CSR_DATA_W-1:0] hold;
      logic [CSR_DATA_W-1:0] rep;
      random_sent = 0;
      phase = 0;
      levels = PINS_IDLE;
      foreach (run_left[b]) run_left[b] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[r]) begin
         if (DIRECTED[r].kind == ROW_CSR)
            csr_write(DIRECTED[r].idx, DIRECTED[r].data);
         else
            repeat (DIRECTED[r].reps)
               send_tick(DIRECTED[r].pins, DIRECTED[r].typed, DIRECTED[r].want);
      end

      while (random_sent < RANDOM_ITEMS) begin
         case (phase)
            0: begin
               div = '0; auto_on = 1'b1; hold = 15'h7FFF; rep = 15'h7FFF;
            end
            1: begin
               div = 8'hFF; auto_on = 1'b1; hold = '0; rep = '0;
            end
            default: begin
               pick = $urandom_range(0, 19);
               if (pick == 0) div = '0;
               else if (pick == 1) div = 8'hFF;
               else if (pick < 5) div = DIVIDER_W'($urandom_range(5, 40));
               else div = DIVIDER_W'($urandom_range(1, 4));
               auto_on = ($urandom_range(0, 3) != 0);
               hold = ($urandom_range(0, 9) == 0) ? CSR_DATA_W'($urandom_range(0, 32767))
                                                  : CSR_DATA_W'($urandom_range(0, 6));
               rep = ($urandom_range(0, 9) == 0) ? 15'h7FFF : CSR_DATA_W'($urandom_range(0, 4));
            end
         endcase
         csr_write(CSR_SAMPLE_DIVIDER, CSR_DATA_W'(div));
         csr_write(CSR_AUTOREPEAT_ON, CSR_DATA_W'(auto_on));
         csr_write(CSR_HOLD_SAMPLES, hold);
         csr_write(CSR_REPEAT_SAMPLES, rep);

         div_ticks = (div == '0) ? 256 : int'(div);
         if (div_ticks >= 200) phase_len = $urandom_range(260, 300);
         else if (div_ticks > 4) phase_len = $urandom_range(150, 300);
         else phase_len = $urandom_range(40, 120);
         pick = $urandom_range(0, 2);
         send_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 8 : 25;
         pick = $urandom_range(0, 2);
         rsp_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 8 : 25;
         if (phase == 2) begin
            send_idle_pct = 0;
            long_stall_req = 1'b1;
         end

         for (int i = 0; i < phase_len && random_sent < RANDOM_ITEMS; i++) begin
            quiet = (random_sent >= RANDOM_ITEMS - QUIET_ITEMS);
            foreach (run_left[b]) begin
               if (run_left[b] == 0) begin
                  levels[b] = ~levels[b];
                  run_left[b] = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                                                           : $urandom_range(1, 12) * div_ticks;
               end
               run_left[b]--;
            end
            send_tick(levels, 1'b0, QUIET_TICK);
            random_sent++;
         end
         phase++;
      end

      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

### button_debounce_autorepeat.f
rtl/bda_pkg.sv
rtl/button_debounce_autorepeat.sv
bench/tb.sv
